>>> hdl/pds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants for the pairwise distance statistics block.
// ----------------------------------------------------------------------------
package pds_pkg;

  // Field widths of the channels
  localparam int IN_COORD_W = 24;
  localparam int DIST_W     = 25;
  localparam int STATUS_W   = 2;

  // Sizing
  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 24;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int POINT_W    = 3 * COORD_BITS;

  // Distance datapath
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int SUMSQ_W    = SQ_W + 2;
  localparam int ROOT_W     = SUMSQ_W / 2;
  localparam int SQRT_ITER  = ROOT_W;

  // Accumulators and divider
  localparam int PAIR_SUM_W = DIST_W + 2 * CNT_W - 1;
  localparam int EDGE_SUM_W = DIST_W + CNT_W;
  localparam int DVS_W      = 2 * CNT_W - 1;
  localparam int DIV_ITER   = PAIR_SUM_W;
  localparam int ITER_W     = $clog2(DIV_ITER + 1);

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FEW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OVER = 2'd2;

  typedef enum logic [3:0] {
    S_LOAD,
    S_START,
    S_RDI,
    S_LATI,
    S_RDJ,
    S_DIFF,
    S_SQ,
    S_SUM,
    S_SQRT,
    S_ACC,
    S_DIVM,
    S_DIVE_LD,
    S_DIVE,
    S_FIN,
    S_OUT
  } pds_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic              store;
    logic              clear;
    logic              init;
    logic              few;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              lat_i;
    logic              diff;
    logic              sq;
    logic              sum_ld;
    logic              sqrt_step;
    logic              acc;
    logic              acc_last_j;
    logic              div_ld_mean;
    logic              div_ld_edge;
    logic              div_step;
    logic              wr_mean;
    logic              wr_edge;
  } pds_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [CNT_W-1:0] count;
  } pds_stat_t;

endpackage : pds_pkg
`default_nettype wire

>>> hdl/pds_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pds_in_if / pds_out_if
// Valid/ready channels carrying one point in and one statistics item out.
// ----------------------------------------------------------------------------
interface pds_in_if;
  import pds_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [IN_COORD_W-1:0] x_coord;
  logic signed [IN_COORD_W-1:0] y_coord;
  logic signed [IN_COORD_W-1:0] z_coord;
  logic                         last_point;
  modport source (output valid, x_coord, y_coord, z_coord, last_point, input ready);
  modport sink   (input valid, x_coord, y_coord, z_coord, last_point, output ready);
endinterface : pds_in_if

interface pds_out_if;
  import pds_pkg::*;
  logic                valid;
  logic                ready;
  logic [DIST_W-1:0]   min_distance;
  logic [DIST_W-1:0]   mean_distance;
  logic [DIST_W-1:0]   border_radius;
  logic [10:0]         point_count;
  logic [STATUS_W-1:0] status;
  modport source (output valid, min_distance, mean_distance, border_radius, point_count,
                  status, input ready);
  modport sink   (input valid, min_distance, mean_distance, border_radius, point_count,
                  status, output ready);
endinterface : pds_out_if
`default_nettype wire

>>> hdl/pds_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pds_ctrl
// Sequencer: load phase, pair loop, square-root and divide iterations.
// ----------------------------------------------------------------------------
module pds_ctrl
  import pds_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_last,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire pds_stat_t stat,
  output pds_cmd_t       cmd
);

  pds_state_t        state_r, state_nxt;
  logic [ADDR_W-1:0] i_r, i_nxt;
  logic [ADDR_W-1:0] j_r, j_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic              last_j;
  logic              last_i;

  // loop end tests against the stored count
  assign last_j = ({1'b0, j_r} + CNT_W'(1)) == stat.count;
  assign last_i = ({1'b0, i_r} + CNT_W'(2)) == stat.count;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD:    if (in_valid && in_last) state_nxt = S_START;
      S_START:   state_nxt = (stat.count < CNT_W'(2)) ? S_OUT : S_RDI;
      S_RDI:     state_nxt = S_LATI;
      S_LATI:    state_nxt = S_RDJ;
      S_RDJ:     state_nxt = S_DIFF;
      S_DIFF:    state_nxt = S_SQ;
      S_SQ:      state_nxt = S_SUM;
      S_SUM:     state_nxt = S_SQRT;
      S_SQRT:    if (iter_r == ITER_W'(SQRT_ITER - 1)) state_nxt = S_ACC;
      S_ACC: begin
        if (!last_j)     state_nxt = S_RDJ;
        else if (last_i) state_nxt = S_DIVM;
        else             state_nxt = S_RDI;
      end
      S_DIVM:    if (iter_r == ITER_W'(DIV_ITER)) state_nxt = S_DIVE_LD;
      S_DIVE_LD: state_nxt = S_DIVE;
      S_DIVE:    if (iter_r == ITER_W'(DIV_ITER - 1)) state_nxt = S_FIN;
      S_FIN:     state_nxt = S_OUT;
      S_OUT:     if (out_ready) state_nxt = S_LOAD;
      default:   state_nxt = S_LOAD;
    endcase
  end

  // outputs and loop counters
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    i_nxt     = i_r;
    j_nxt     = j_r;
    iter_nxt  = iter_r;
    cmd.rd_addr = i_r;
    unique case (state_r)
      S_LOAD: begin
        in_ready  = 1'b1;
        cmd.store = in_valid;
      end
      S_START: begin
        cmd.init = 1'b1;
        cmd.few  = stat.count < CNT_W'(2);
        i_nxt    = '0;
      end
      S_RDI: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = i_r;
      end
      S_LATI: begin
        cmd.lat_i = 1'b1;
        j_nxt     = i_r + ADDR_W'(1);
      end
      S_RDJ: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_addr = j_r;
      end
      S_DIFF: cmd.diff = 1'b1;
      S_SQ:   cmd.sq   = 1'b1;
      S_SUM: begin
        cmd.sum_ld = 1'b1;
        iter_nxt   = '0;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        iter_nxt      = iter_r + ITER_W'(1);
      end
      S_ACC: begin
        cmd.acc        = 1'b1;
        cmd.acc_last_j = last_j;
        j_nxt          = j_r + ADDR_W'(1);
        if (last_j) i_nxt = i_r + ADDR_W'(1);
        iter_nxt       = '0;
      end
      S_DIVM: begin
        // load on entry (iter_r zero), then DIV_ITER divide steps
        if (iter_r == '0) cmd.div_ld_mean = 1'b1;
        else              cmd.div_step    = 1'b1;
        iter_nxt = iter_r + ITER_W'(1);
      end
      S_DIVE_LD: begin
        cmd.wr_mean     = 1'b1;
        cmd.div_ld_edge = 1'b1;
        iter_nxt        = '0;
      end
      S_DIVE: begin
        cmd.div_step = 1'b1;
        iter_nxt     = iter_r + ITER_W'(1);
      end
      S_FIN: cmd.wr_edge = 1'b1;
      S_OUT: begin
        out_valid = 1'b1;
        cmd.clear = out_ready;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      i_r     <= '0;
      j_r     <= '0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      iter_r  <= iter_nxt;
    end
  end

endmodule : pds_ctrl
`default_nettype wire

>>> hdl/pds_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pds_dp
// Point store, distance pipe with bit-serial square root, accumulators and
// a restoring divider shared by the mean and the edge radius.
// ----------------------------------------------------------------------------
module pds_dp
  import pds_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire pds_cmd_t                     cmd,
  input  wire logic signed [IN_COORD_W-1:0] in_x,
  input  wire logic signed [IN_COORD_W-1:0] in_y,
  input  wire logic signed [IN_COORD_W-1:0] in_z,
  output pds_stat_t                         stat,
  output logic [DIST_W-1:0]                 min_dist,
  output logic [DIST_W-1:0]                 mean_dist,
  output logic [DIST_W-1:0]                 edge_rad,
  output logic [CNT_W-1:0]                  count,
  output logic [STATUS_W-1:0]               status
);

  logic [POINT_W-1:0]      mem [MAX_POINTS];
  logic [POINT_W-1:0]      rdata_r;
  logic [POINT_W-1:0]      pi_r;
  logic [CNT_W-1:0]        count_r;
  logic                    over_r;
  logic [COORD_BITS-1:0]   ad_r [3];
  logic [SQ_W-1:0]         sq_r [3];
  logic [SUMSQ_W-1:0]      val_r;
  logic [ROOT_W:0]         rem_r;
  logic [ROOT_W-1:0]       root_r;
  logic [ROOT_W+2:0]       s_t;
  logic [ROOT_W+2:0]       s_trial;
  logic                    s_ge;
  logic [DIST_W-1:0]       pair_dist;
  logic [DIST_W-1:0]       near_r;
  logic [DIST_W-1:0]       near_new;
  logic [PAIR_SUM_W-1:0]   psum_r;
  logic [EDGE_SUM_W-1:0]   esum_r;
  logic [DVS_W-1:0]        pdiv_r;
  logic [DVS_W-1:0]        ediv_r;
  logic [2*CNT_W-1:0]      nn1;
  logic [PAIR_SUM_W-1:0]   dvd_r;
  logic [DVS_W-1:0]        dvs_r;
  logic [DVS_W-1:0]        drem_r;
  logic [DVS_W:0]          d_t;
  logic                    d_ge;
  logic [DIST_W-1:0]       min_r, mean_r, edge_r;
  logic [STATUS_W-1:0]     status_r;
  logic                    full;

  assign full = count_r == CNT_W'(MAX_POINTS);

  // point store, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store && !full)
      mem[count_r[ADDR_W-1:0]] <= {in_x[COORD_BITS-1:0], in_y[COORD_BITS-1:0],
                                   in_z[COORD_BITS-1:0]};
    if (cmd.rd_en) rdata_r <= mem[cmd.rd_addr];
  end

  // fill count and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      count_r <= '0;
      over_r  <= 1'b0;
    end else if (cmd.store) begin
      if (full) over_r  <= 1'b1;
      else      count_r <= count_r + CNT_W'(1);
    end
  end

  // absolute differences, squares, sum of squares
  always_ff @(posedge clk) begin
    if (cmd.lat_i) pi_r <= rdata_r;
    for (int k = 0; k < 3; k++) begin
      if (cmd.diff) begin
        if ($signed(pi_r[k*COORD_BITS +: COORD_BITS]) >=
            $signed(rdata_r[k*COORD_BITS +: COORD_BITS]))
          ad_r[k] <= pi_r[k*COORD_BITS +: COORD_BITS] - rdata_r[k*COORD_BITS +: COORD_BITS];
        else
          ad_r[k] <= rdata_r[k*COORD_BITS +: COORD_BITS] - pi_r[k*COORD_BITS +: COORD_BITS];
      end
      if (cmd.sq) sq_r[k] <= ad_r[k] * ad_r[k];
    end
  end

  // square root step: two bits of the radicand per cycle
  assign s_t     = {rem_r, val_r[SUMSQ_W-1 -: 2]};
  assign s_trial = {1'b0, root_r, 2'b01};
  assign s_ge    = s_t >= s_trial;

  always_ff @(posedge clk) begin
    if (cmd.sum_ld) begin
      val_r  <= SUMSQ_W'(sq_r[0]) + SUMSQ_W'(sq_r[1]) + SUMSQ_W'(sq_r[2]);
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.sqrt_step) begin
      val_r  <= {val_r[SUMSQ_W-3:0], 2'b00};
      rem_r  <= s_ge ? (ROOT_W+1)'(s_t - s_trial) : (ROOT_W+1)'(s_t);
      root_r <= {root_r[ROOT_W-2:0], s_ge};
    end
  end

  assign pair_dist = (root_r > ROOT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(root_r);
  assign near_new  = (pair_dist < near_r) ? pair_dist : near_r;
  assign nn1       = count_r * (count_r - CNT_W'(1));

  // accumulators, minimum and nearest-later tracking
  always_ff @(posedge clk) begin
    if (cmd.init) begin
      psum_r   <= '0;
      esum_r   <= '0;
      min_r    <= cmd.few ? '0 : DIST_MAX;
      mean_r   <= '0;
      edge_r   <= '0;
      pdiv_r   <= DVS_W'(nn1 >> 1);
      ediv_r   <= DVS_W'({count_r - CNT_W'(1), 1'b0});
      status_r <= cmd.few ? STATUS_FEW : (over_r ? STATUS_OVER : STATUS_OK);
    end else begin
      if (cmd.acc) begin
        psum_r <= psum_r + PAIR_SUM_W'(pair_dist);
        if (pair_dist < min_r) min_r <= pair_dist;
        if (cmd.acc_last_j) esum_r <= esum_r + EDGE_SUM_W'(near_new);
      end
      if (cmd.wr_mean) mean_r <= DIST_W'(dvd_r);
      if (cmd.wr_edge) edge_r <= DIST_W'(dvd_r);
    end
    if (cmd.lat_i) near_r <= DIST_MAX;
    else if (cmd.acc) near_r <= near_new;
  end

  // restoring divider, one quotient bit per cycle
  assign d_t  = {drem_r, dvd_r[PAIR_SUM_W-1]};
  assign d_ge = d_t >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.div_ld_mean) begin
      dvd_r  <= psum_r;
      dvs_r  <= pdiv_r;
      drem_r <= '0;
    end else if (cmd.div_ld_edge) begin
      dvd_r  <= PAIR_SUM_W'(esum_r);
      dvs_r  <= ediv_r;
      drem_r <= '0;
    end else if (cmd.div_step) begin
      drem_r <= d_ge ? DVS_W'(d_t - {1'b0, dvs_r}) : DVS_W'(d_t);
      dvd_r  <= {dvd_r[PAIR_SUM_W-2:0], d_ge};
    end
  end

  assign stat.count = count_r;
  assign min_dist   = min_r;
  assign mean_dist  = mean_r;
  assign edge_rad   = edge_r;
  assign count      = count_r;
  assign status     = status_r;

endmodule : pds_dp
`default_nettype wire

>>> hdl/pairwise_distance_statistics_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pairwise_distance_statistics_top
// Minimum, mean and edge radius over all pairwise distances of a point set.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one 3-D point per item; the item with last_point set closes
//   the set. Up to MAX_POINTS points are kept, later ones are dropped and the
//   result status reads "capacity exceeded".
//   out_ch carries one statistics item per closed set.
// Sequence:
//   Loading accepts one item per cycle. After the last item the block works
//   through every pair before it offers the result: each pair passes the
//   read, difference, square, sum and accumulate steps plus 25 square-root
//   iterations, the mean and the edge radius each take one 46-step division
//   in the shared divider, and start, load and write steps make up the rest.
//   With fewer than two points the result is offered without the pair loop.
// Stall and reset:
//   While the computation runs or the result waits, in_ch.ready is low; the
//   result holds on out_ch until taken, then the set is cleared. Reset empties
//   the set; the point store needs no clearing.
// ----------------------------------------------------------------------------
module pairwise_distance_statistics_top
  import pds_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst_n,
  pds_in_if.sink    in_ch,
  pds_out_if.source out_ch
);

  pds_cmd_t  cmd;
  pds_stat_t stat;
  logic [CNT_W-1:0] count;

  pds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last_point),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pds_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_x      (in_ch.x_coord),
    .in_y      (in_ch.y_coord),
    .in_z      (in_ch.z_coord),
    .stat      (stat),
    .min_dist  (out_ch.min_distance),
    .mean_dist (out_ch.mean_distance),
    .edge_rad  (out_ch.border_radius),
    .count     (count),
    .status    (out_ch.status)
  );

  assign out_ch.point_count = 11'(count);

endmodule : pairwise_distance_statistics_top
`default_nettype wire
